// File: sv/cdq_pkg.sv
// cdq_pkg: shared constants and types for the circular deque
// no dependencies; used by the interfaces and the top level
package cdq_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned SW    = AW + 1;
  localparam int unsigned DW    = 32;
  localparam int unsigned OPW   = 3;
  localparam int unsigned STW   = 2;

  typedef enum logic [OPW-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_PEEK_BACK  = 3'd4,
    OP_PEEK_FRONT = 3'd5
  } opcode_e;

  typedef enum logic [STW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

// File: sv/cdq_in_if.sv
// cdq_in_if: request channel of the circular deque (opcode and value)
// depends on cdq_pkg
interface cdq_in_if;
  logic                          valid;
  logic                          ready;
  logic [cdq_pkg::OPW-1:0]       opcode;
  logic signed [cdq_pkg::DW-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

// File: sv/cdq_out_if.sv
// cdq_out_if: result channel of the circular deque (data, status, occupancy)
// depends on cdq_pkg
interface cdq_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [cdq_pkg::DW-1:0] data;
  logic [cdq_pkg::STW-1:0]       status;
  logic [cdq_pkg::CW-1:0]        occupancy;

  modport source (output valid, output data, output status, output occupancy, input ready);
  modport sink   (input valid, input data, input status, input occupancy, output ready);
endinterface

// File: sv/circular_deque.sv
// circular_deque: double-ended queue of 32-bit words in a circular ram
// depends on cdq_pkg, cdq_in_if, cdq_out_if and cdq_ram
//
//   channel | dir | handshake     | payload
//   req_i   | in  | valid / ready | opcode, value
//   rsp_o   | out | valid / ready | data, status, occupancy
//
// one transaction per cycle when the result side keeps up; each result
// passes the ram read and pending stage, then the output register.
// head and count update at request time, so a pop right after a push sees it.
// reset clears head, count and the pipeline valids; the ram is not cleared.
// a stalled result holds the pending stage and the ram read register.
module circular_deque (
  input  logic clk_i,
  input  logic rst_ni,
  cdq_in_if.sink    req_i,
  cdq_out_if.source rsp_o
);

  localparam logic [cdq_pkg::CW-1:0] DepthC = cdq_pkg::CW'(cdq_pkg::DEPTH);
  localparam logic [cdq_pkg::AW-1:0] LastC  = cdq_pkg::AW'(cdq_pkg::DEPTH - 1);
  localparam logic [cdq_pkg::SW-1:0] DepthS = cdq_pkg::SW'(cdq_pkg::DEPTH);

  logic [cdq_pkg::AW-1:0] head_q, head_d;
  logic [cdq_pkg::CW-1:0] count_q, count_d;

  logic                   p_valid_q, p_valid_d;
  logic                   p_rd_q, p_rd_d;
  cdq_pkg::status_e       p_status_q, p_status_d;
  logic [cdq_pkg::CW-1:0] p_occ_q;

  logic                   o_valid_q;
  logic [cdq_pkg::DW-1:0] o_data_q;
  cdq_pkg::status_e       o_status_q;
  logic [cdq_pkg::CW-1:0] o_occ_q;

  logic                   accept;
  logic                   o_load;
  logic                   p_adv;

  logic                   we;
  logic [cdq_pkg::AW-1:0] waddr;
  logic                   re;
  logic [cdq_pkg::AW-1:0] raddr;
  logic [cdq_pkg::DW-1:0] rdata;

  logic [cdq_pkg::SW-1:0] tail_sum;
  logic [cdq_pkg::SW-1:0] back_sum;
  logic [cdq_pkg::AW-1:0] tail_slot;
  logic [cdq_pkg::AW-1:0] back_slot;
  logic                   is_full;
  logic                   is_empty;

  // handshake
  assign o_load       = !o_valid_q || rsp_o.ready;
  assign p_adv        = p_valid_q && o_load;
  assign req_i.ready  = !p_valid_q || o_load;
  assign accept       = req_i.valid && req_i.ready;

  // slot arithmetic
  assign is_full   = (count_q == DepthC);
  assign is_empty  = (count_q == '0);
  assign tail_sum  = cdq_pkg::SW'(head_q) + cdq_pkg::SW'(count_q);
  assign back_sum  = tail_sum - cdq_pkg::SW'(1);
  assign tail_slot = (tail_sum >= DepthS) ? cdq_pkg::AW'(tail_sum - DepthS)
                                          : cdq_pkg::AW'(tail_sum);
  assign back_slot = (back_sum >= DepthS) ? cdq_pkg::AW'(back_sum - DepthS)
                                          : cdq_pkg::AW'(back_sum);

  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    we         = 1'b0;
    waddr      = tail_slot;
    re         = 1'b0;
    raddr      = head_q;
    p_rd_d     = 1'b0;
    p_status_d = cdq_pkg::ST_OK;
    case (cdq_pkg::opcode_e'(req_i.opcode))
      cdq_pkg::OP_PUSH_BACK: begin
        if (is_full) begin
          p_status_d = cdq_pkg::ST_FULL;
        end else begin
          we      = accept;
          count_d = count_q + cdq_pkg::CW'(1);
        end
      end
      cdq_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          p_status_d = cdq_pkg::ST_FULL;
        end else begin
          head_d  = (head_q == '0) ? LastC : head_q - cdq_pkg::AW'(1);
          waddr   = head_d;
          we      = accept;
          count_d = count_q + cdq_pkg::CW'(1);
        end
      end
      cdq_pkg::OP_POP_BACK, cdq_pkg::OP_PEEK_BACK: begin
        if (is_empty) begin
          p_status_d = cdq_pkg::ST_EMPTY;
        end else begin
          raddr  = back_slot;
          re     = accept;
          p_rd_d = 1'b1;
          if (cdq_pkg::opcode_e'(req_i.opcode) == cdq_pkg::OP_POP_BACK) begin
            count_d = count_q - cdq_pkg::CW'(1);
          end
        end
      end
      cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_PEEK_FRONT: begin
        if (is_empty) begin
          p_status_d = cdq_pkg::ST_EMPTY;
        end else begin
          re     = accept;
          p_rd_d = 1'b1;
          if (cdq_pkg::opcode_e'(req_i.opcode) == cdq_pkg::OP_POP_FRONT) begin
            head_d  = (head_q == LastC) ? '0 : head_q + cdq_pkg::AW'(1);
            count_d = count_q - cdq_pkg::CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign p_valid_d = accept ? 1'b1 : (p_adv ? 1'b0 : p_valid_q);

  cdq_ram #(
    .WIDTH (cdq_pkg::DW),
    .DEPTH (cdq_pkg::DEPTH),
    .AW    (cdq_pkg::AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (req_i.value),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
      if (accept) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
      if (o_load) begin
        o_valid_q <= p_valid_q;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_rd_q     <= p_rd_d;
      p_status_q <= p_status_d;
      p_occ_q    <= count_d;
    end
    if (p_adv) begin
      o_data_q   <= p_rd_q ? rdata : '0;
      o_status_q <= p_status_q;
      o_occ_q    <= p_occ_q;
    end
  end

  assign rsp_o.valid     = o_valid_q;
  assign rsp_o.data      = o_data_q;
  assign rsp_o.status    = o_status_q;
  assign rsp_o.occupancy = o_occ_q;

endmodule

// File: sv/cdq_ram.sv
// cdq_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
